### design/tswdt_pkg.sv
// ----------------------------------------------------------------------------
// tswdt_pkg
// Shared constants for the two-stage watchdog timer: beat modes, register
// offsets, the kick word and the reload reset word.
// ----------------------------------------------------------------------------
package tswdt_pkg;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;
   localparam logic [1:0] MODE_IDLE  = 2'd3;

   localparam logic [7:0] OFS_ENABLE = 8'h00;
   localparam logic [7:0] OFS_RELOAD = 8'h0c;
   localparam logic [7:0] OFS_LOAD   = 8'h18;
   localparam logic [7:0] OFS_COUNT  = 8'h24;
   localparam logic [7:0] OFS_KICK   = 8'h30;
   localparam logic [7:0] OFS_ICLR   = 8'h3c;
   localparam logic [7:0] OFS_IEN    = 8'h54;

   localparam logic [31:0] KICK_WORD       = 32'h6169_6370;
   localparam logic [31:0] RELOAD_RST_WORD = 32'h0000_ffff;

endpackage

### design/two_stage_watchdog_timer.sv
// ----------------------------------------------------------------------------
// two_stage_watchdog_timer
// Watchdog with a staged reload, kick word, interrupt on first expiry and a
// sticky reset request on second expiry. One tick, read or write per beat.
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction
//  ---------+--------------------------------+----------
//  request  | req_valid/ready, mode/addr/wd  | in
//  response | rsp_valid/ready, rdata/irq/rst | out
//
//  One beat per cycle sustained while rsp_ready holds; a request beat passes
//  the input register, then the result register, before its response appears.
//  The input register takes a new beat while a response waits on a stall, if it is empty.
//  Synchronous reset clears control state and sets the counter to
//  reload << TICK_SHIFT with reload all ones (low 16 bits).
// ----------------------------------------------------------------------------
module two_stage_watchdog_timer #(
   parameter int TICK_SHIFT  = 16,
   parameter int RELOAD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_addr,
   input  logic [31:0] req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_rdata,
   output logic        rsp_irq,
   output logic        rsp_reset_out
);
   import tswdt_pkg::*;

   localparam logic [RELOAD_BITS-1:0] RELOAD_RST = RELOAD_BITS'(RELOAD_RST_WORD);

   logic                   in_valid_ff;
   logic [1:0]             mode_ff;
   logic [7:0]             addr_ff;
   logic [31:0]            wdata_ff;

   logic                   enabled_ff,       enabled_in;
   logic [RELOAD_BITS-1:0] staged_reload_ff, staged_reload_in;
   logic [RELOAD_BITS-1:0] active_reload_ff, active_reload_in;
   logic [31:0]            count_ff,         count_in;
   logic                   second_stage_ff,  second_stage_in;
   logic                   irq_pending_ff,   irq_pending_in;
   logic                   irq_enable_ff,    irq_enable_in;
   logic                   reset_latched_ff, reset_latched_in;

   logic                   rsp_valid_ff;
   logic [31:0]            rdata_ff, rdata_in;
   logic                   irq_ff;
   logic                   reset_out_ff;

   logic                   out_free;
   logic                   advance;
   logic                   req_take;
   logic [63:0]            refill_wide;
   logic [31:0]            refill_val;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign refill_wide = 64'(active_reload_ff) << TICK_SHIFT;
   assign refill_val  = refill_wide[31:0];

   always_comb begin
      enabled_in       = enabled_ff;
      staged_reload_in = staged_reload_ff;
      active_reload_in = active_reload_ff;
      count_in         = count_ff;
      second_stage_in  = second_stage_ff;
      irq_pending_in   = irq_pending_ff;
      irq_enable_in    = irq_enable_ff;
      reset_latched_in = reset_latched_ff;
      rdata_in         = '0;
      case (mode_ff)
         MODE_TICK: begin
            if (enabled_ff) begin
               if (count_ff != '0) begin
                  count_in = count_ff - 32'd1;
               end else begin
                  if (!second_stage_ff) begin
                     irq_pending_in  = 1'b1;
                     second_stage_in = 1'b1;
                  end else begin
                     reset_latched_in = 1'b1;
                  end
                  count_in = refill_val;
               end
            end
         end
         MODE_READ: begin
            case (addr_ff)
               OFS_ENABLE: rdata_in = 32'(enabled_ff);
               OFS_RELOAD: rdata_in = 32'(staged_reload_ff);
               OFS_COUNT:  rdata_in = count_ff;
               OFS_IEN:    rdata_in = 32'(irq_enable_ff);
               default:    rdata_in = '0;
            endcase
         end
         MODE_WRITE: begin
            case (addr_ff)
               OFS_ENABLE: enabled_in = wdata_ff[0];
               OFS_RELOAD: staged_reload_in = wdata_ff[RELOAD_BITS-1:0];
               OFS_LOAD: begin
                  if (wdata_ff[0]) begin
                     active_reload_in = staged_reload_ff;
                     second_stage_in  = 1'b0;
                     count_in = 32'((64'(staged_reload_ff) << TICK_SHIFT) & 64'hffff_ffff);
                  end
               end
               OFS_KICK: begin
                  if (wdata_ff == KICK_WORD) begin
                     second_stage_in = 1'b0;
                     count_in        = refill_val;
                  end
               end
               OFS_ICLR: begin
                  if (wdata_ff[0]) begin
                     irq_pending_in = 1'b0;
                  end
               end
               OFS_IEN:    irq_enable_in = wdata_ff[0];
               default:    enabled_in = enabled_ff;
            endcase
         end
         MODE_IDLE: rdata_in = '0;
         default:   rdata_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff  <= req_mode;
         addr_ff  <= req_addr;
         wdata_ff <= req_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff       <= 1'b0;
         staged_reload_ff <= RELOAD_RST;
         active_reload_ff <= RELOAD_RST;
         count_ff         <= 32'((64'(RELOAD_RST) << TICK_SHIFT) & 64'hffff_ffff);
         second_stage_ff  <= 1'b0;
         irq_pending_ff   <= 1'b0;
         irq_enable_ff    <= 1'b0;
         reset_latched_ff <= 1'b0;
      end else if (advance) begin
         enabled_ff       <= enabled_in;
         staged_reload_ff <= staged_reload_in;
         active_reload_ff <= active_reload_in;
         count_ff         <= count_in;
         second_stage_ff  <= second_stage_in;
         irq_pending_ff   <= irq_pending_in;
         irq_enable_ff    <= irq_enable_in;
         reset_latched_ff <= reset_latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rdata_ff     <= rdata_in;
         irq_ff       <= irq_pending_in && irq_enable_in;
         reset_out_ff <= reset_latched_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rdata     = rdata_ff;
   assign rsp_irq       = irq_ff;
   assign rsp_reset_out = reset_out_ff;

   a_reset_sticky: assert property (@(posedge clock) disable iff (reset)
      reset_latched_ff |=> reset_latched_ff)
      else $error("reset request dropped");

   a_reset_after_stage2: assert property (@(posedge clock) disable iff (reset)
      $rose(reset_latched_ff) |-> $past(second_stage_ff))
      else $error("reset request without second stage");

   a_irq_enters_stage2: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_pending_ff) |-> second_stage_ff)
      else $error("interrupt pending outside second stage");

   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response without a buffered request");

endmodule
